### sv/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the sextet-to-character lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharUpper = 8'h41;  // 'A'
  localparam logic [7:0] CharLower = 8'h61;  // 'a'
  localparam logic [7:0] CharDigit = 8'h30;  // '0'
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
  localparam logic [7:0] CharSlash = 8'h2f;  // '/'

  // One closed group as handed from the front to the back.
  typedef struct packed {
    logic [23:0] bits;   // up to three bytes, zero-filled
    logic [1:0]  held;   // bytes held before the closing byte (0..2)
    logic        last;   // group closes the message
  } b64enc_group_t;

  // Map a 6-bit value to its standard-alphabet character.
  function automatic logic [7:0] b64enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return CharUpper + w;
    else if (v < 6'd52) return CharLower + (w - 8'd26);
    else if (v < 6'd62) return CharDigit + (w - 8'd52);
    else if (v == 6'd62) return CharPlus;
    else                return CharSlash;
  endfunction

endpackage

`default_nettype wire

### sv/b64enc_intf.sv
// ----------------------------------------------------------------------------
// Base64 encoder channel interfaces
// Byte input channel and character output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64enc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

`default_nettype wire

### sv/b64enc_front.sv
// ----------------------------------------------------------------------------
// Base64 encoder front
// Collect bytes into groups of three; close a group on its third or last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  b64enc_byte_if.sink                  byte_i,
  output      b64enc_pkg::b64enc_group_t grp_o,
  output      logic                    grp_valid_o,
  input  wire logic                    grp_ready_i
);
  import b64enc_pkg::*;

  logic [1:0] held_q, held_d;
  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic       accept;
  logic       close;

  assign byte_i.ready = grp_ready_i;
  assign accept       = byte_i.valid & grp_ready_i;
  assign close        = (held_q == 2'd2) | byte_i.last_byte;
  assign grp_valid_o  = accept & close;

  always_comb begin
    held_d       = held_q;
    pend0_d      = pend0_q;
    pend1_d      = pend1_q;
    grp_o.held   = held_q;
    grp_o.last   = byte_i.last_byte;
    unique case (held_q)
      2'd1:    grp_o.bits = {pend0_q, byte_i.data_byte, 8'h00};
      2'd2:    grp_o.bits = {pend0_q, pend1_q, byte_i.data_byte};
      default: grp_o.bits = {byte_i.data_byte, 16'h0000};
    endcase
    if (accept) begin
      if (close) begin
        held_d = 2'd0;
      end else begin
        if (held_q == 2'd0) pend0_d = byte_i.data_byte;
        else                pend1_d = byte_i.data_byte;
        held_d = held_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 2'd0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

endmodule

`default_nettype wire

### sv/b64enc_queue.sv
// ----------------------------------------------------------------------------
// Base64 encoder group queue
// Two-entry queue of closed groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire b64enc_pkg::b64enc_group_t push_grp_i,
  input  wire logic                      push_i,
  output      logic                      push_ready_o,
  output      b64enc_pkg::b64enc_group_t head_o,
  output      logic                      head_valid_o,
  input  wire logic                      pop_i
);
  import b64enc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  b64enc_group_t       mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push & ~do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (do_pop & ~do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_grp_i;
  end

endmodule

`default_nettype wire

### sv/b64enc_back.sv
// ----------------------------------------------------------------------------
// Base64 encoder back
// Serialize one group into four characters through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire b64enc_pkg::b64enc_group_t head_i,
  input  wire logic                      head_valid_i,
  output      logic                      pop_o,
  b64enc_char_if.source                  char_o
);
  import b64enc_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] chr_q, chr_d;
  logic       eot_q, eot_d;
  logic       load;
  logic [5:0] sextet;

  assign load = head_valid_i & (~vld_q | char_o.ready);
  assign pop_o = load & (idx_q == 2'd3);

  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = head_i.bits[23:18];
      2'd1:    sextet = head_i.bits[17:12];
      2'd2:    sextet = head_i.bits[11:6];
      default: sextet = head_i.bits[5:0];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q & ~char_o.ready;
    chr_d = chr_q;
    eot_d = eot_q;
    if (load) begin
      vld_d = 1'b1;
      idx_d = idx_q + 2'd1;
      // Characters past held+1 are padding.
      chr_d = (idx_q <= (head_i.held + 2'd1)) ? b64enc_char(sextet) : CharPad;
      eot_d = head_i.last & (idx_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    eot_q <= eot_d;
  end

  assign char_o.valid       = vld_q;
  assign char_o.out_char    = chr_q;
  assign char_o.end_of_text = eot_q;

endmodule

`default_nettype wire

### sv/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream in, RFC 4648 standard-alphabet characters with '=' padding out.
// ----------------------------------------------------------------------------
// Send the message one byte per transaction on byte_i, with last_byte set on
// its final byte. Every third byte, and the final byte, closes a group that
// comes out as four characters on char_o, one per transaction, most
// significant sextet first; a final group of one or two bytes is zero-filled
// and padded with '=' to four characters, and the fourth character of the
// final group has end_of_text set. The front takes one byte per cycle while
// the two-entry group queue has room; the back drives one character per
// cycle while char_o is ready, so four characters per three bytes limit the
// sustained input rate. A closing byte's group is written into the queue, and
// its first character is then loaded into the output character register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b64enc_byte_if.sink   byte_i,
  b64enc_char_if.source char_o
);
  import b64enc_pkg::*;

  // Closed groups from the front toward the queue.
  b64enc_group_t grp;
  logic          grp_valid;
  logic          grp_ready;

  // Queue head toward the back.
  b64enc_group_t head;
  logic          head_valid;
  logic          pop;

  // Assemble groups; stall input only when the queue is full.
  b64enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .grp_o       (grp),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready)
  );

  // Decouple input bursts from output stalls.
  b64enc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_grp_i   (grp),
    .push_i       (grp_valid),
    .push_ready_o (grp_ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  // Emit four characters per group; pop as the fourth is loaded.
  b64enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .char_o       (char_o)
  );

endmodule

`default_nettype wire
